FILE: src/dhoat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhoat_pkg
// Shared constants, types and helpers for the double-hashed open-address
// table: sizes, operation and status codes, slot marks, FSM states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dhoat_pkg;

    // Table geometry (TABLE_SIZE must be prime)
    localparam int TABLE_SIZE = 13;
    localparam int IDX_W      = $clog2(TABLE_SIZE);

    // Transaction field widths
    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // Stream bus widths (fields padded to whole bytes)
    localparam int S_TDATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + 7) / 8) * 8;

    // Digit-serial residue unit
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int KEY_SH_W   = NUM_DIGITS * DIGIT_W;
    localparam int DCNT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int ACC_W      = IDX_W + DIGIT_W;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

    // Slot marks
    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_FULL    = 2'd1,
        MARK_DELETED = 2'd2
    } t_mark;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_INIT,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic  load;
        logic  mod_step;
        logic  probe_init;
        logic  probe_adv;
        logic  key_wr;
        logic  mark_wr;
        t_mark mark_val;
        logic  res_hit;
        logic  out_load;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              mod_last;
        t_mark             mark;
        logic              key_eq;
        logic              probe_last;
        logic              out_free;
    } t_sts;

    // One digit step of a residue: (rem * 2^DIGIT_W + dig) mod m, for rem < m.
    // Restoring reduction, one conditional subtract per digit bit.
    function automatic logic [IDX_W-1:0] mod_digit(
        input logic [IDX_W-1:0]   rem,
        input logic [DIGIT_W-1:0] dig,
        input logic [ACC_W-1:0]   m
    );
        logic [ACC_W-1:0] acc;
        acc = {rem, dig};
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            if (acc >= (m << i)) begin
                acc = acc - (m << i);
            end
        end
        return acc[IDX_W-1:0];
    endfunction

endpackage

FILE: src/dhoat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhoat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dhoat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/dhoat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhoat_ctrl
// Controller FSM: accepts a request, runs the residue unit, walks the probe
// sequence probe by probe (read, then check) and hands the result to the output register.
// ----------------------------------------------------------------------------
module dhoat_ctrl
    import dhoat_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_hit;
    logic   w_op_valid;

    // Probe hit decision for the current slot
    always_comb begin
        w_hit      = 1'b0;
        w_op_valid = 1'b0;
        case (i_sts.func) inside
            FUNC_INSERT: begin
                w_hit      = (i_sts.mark != MARK_FULL);
                w_op_valid = 1'b1;
            end
            FUNC_DELETE, FUNC_SEARCH: begin
                w_hit      = (i_sts.mark == MARK_FULL) && i_sts.key_eq;
                w_op_valid = 1'b1;
            end
            default: begin
                w_hit      = 1'b0;
                w_op_valid = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_MOD;
            end
            ST_MOD: begin
                if (i_sts.mod_last) n_state = ST_INIT;
            end
            ST_INIT: begin
                n_state = w_op_valid ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_hit || i_sts.probe_last) n_state = ST_DONE;
                else                           n_state = ST_READ;
            end
            ST_DONE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.mark_val = MARK_EMPTY;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.load    = s_axis_tvalid;
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            ST_INIT: begin
                o_cmd.probe_init = 1'b1;
            end
            ST_READ: begin
                // key RAM read of the current slot is in flight
            end
            ST_CHECK: begin
                if (w_hit) begin
                    o_cmd.res_hit = 1'b1;
                    if (i_sts.func == FUNC_INSERT) begin
                        o_cmd.key_wr   = 1'b1;
                        o_cmd.mark_wr  = 1'b1;
                        o_cmd.mark_val = MARK_FULL;
                    end else if (i_sts.func == FUNC_DELETE) begin
                        o_cmd.mark_wr  = 1'b1;
                        o_cmd.mark_val = MARK_DELETED;
                    end
                end else if (!i_sts.probe_last) begin
                    o_cmd.probe_adv = 1'b1;
                end
            end
            ST_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/dhoat_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhoat_dp
// Datapath: request registers, digit-serial residues mod N and mod N-2,
// probe position stepper, slot marks, key RAM and the output register.
// ----------------------------------------------------------------------------
module dhoat_dp
    import dhoat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [FUNC_W-1:0]    s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [STATUS_W-1:0]  m_axis_tuser,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts
);

    // Request
    logic [FUNC_W-1:0]   r_func;
    logic [KEY_W-1:0]    r_key;
    logic [KEY_SH_W-1:0] r_key_sh;
    logic [DCNT_W-1:0]   r_dcnt;

    // Residues: key mod N and key mod (N-2)
    logic [IDX_W-1:0]    r_res_n;
    logic [IDX_W-1:0]    r_res_n2;
    logic [DIGIT_W-1:0]  w_digit;

    // Probe walk
    logic [IDX_W-1:0]    r_pos;
    logic [IDX_W-1:0]    r_step;
    logic [IDX_W-1:0]    r_pcnt;
    logic [IDX_W:0]      w_pos_sum;
    logic [IDX_W-1:0]    w_pos_next;

    // Table state
    t_mark               r_marks [TABLE_SIZE];
    logic [KEY_W-1:0]    w_rd_key;

    // Result and output register
    logic [STATUS_W-1:0] r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [STATUS_W-1:0] r_out_user;

    assign w_digit = r_key_sh[KEY_SH_W-1 -: DIGIT_W];

    // Request capture and digit-serial reduction, most significant digit first
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= s_axis_tuser;
            r_key    <= s_axis_tdata[KEY_W-1:0];
            r_key_sh <= KEY_SH_W'(s_axis_tdata[KEY_W-1:0]);
            r_dcnt   <= '0;
            r_res_n  <= '0;
            r_res_n2 <= '0;
        end else if (i_cmd.mod_step) begin
            r_key_sh <= r_key_sh << DIGIT_W;
            r_dcnt   <= r_dcnt + 1'b1;
            r_res_n  <= mod_digit(r_res_n, w_digit, ACC_W'(TABLE_SIZE));
            r_res_n2 <= mod_digit(r_res_n2, w_digit, ACC_W'(TABLE_SIZE - 2));
        end
    end

    // Next probe position: pos + step, both below N, one compare-subtract
    always_comb begin
        w_pos_sum = {1'b0, r_pos} + {1'b0, r_step};
        if (w_pos_sum >= (IDX_W+1)'(TABLE_SIZE)) begin
            w_pos_next = IDX_W'(w_pos_sum - (IDX_W+1)'(TABLE_SIZE));
        end else begin
            w_pos_next = w_pos_sum[IDX_W-1:0];
        end
    end

    // Probe walk and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_pos        <= r_res_n;
            r_step       <= r_res_n2 + 1'b1;
            r_pcnt       <= '0;
            r_res_status <= (r_func == FUNC_INSERT) ? STAT_FULL : STAT_MISSING;
            r_res_slot   <= '0;
        end else begin
            if (i_cmd.probe_adv) begin
                r_pos  <= w_pos_next;
                r_pcnt <= r_pcnt + 1'b1;
            end
            if (i_cmd.res_hit) begin
                r_res_status <= STAT_OK;
                r_res_slot   <= SLOT_W'(r_pos);
            end
        end
    end

    // Slot marks, all empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_marks[i] <= MARK_EMPTY;
            end
        end else if (i_cmd.mark_wr) begin
            r_marks[r_pos] <= i_cmd.mark_val;
        end
    end

    // Key store
    dhoat_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.key_wr),
        .i_wr_addr (r_pos),
        .i_wr_data (r_key),
        .i_rd_addr (r_pos),
        .o_rd_data (w_rd_key)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= M_TDATA_W'(r_res_slot);
            r_out_user <= r_res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Status to controller
    assign o_sts.func       = r_func;
    assign o_sts.mod_last   = (r_dcnt == DCNT_W'(NUM_DIGITS - 1));
    assign o_sts.mark       = r_marks[r_pos];
    assign o_sts.key_eq     = (w_rd_key == r_key);
    assign o_sts.probe_last = (r_pcnt == IDX_W'(TABLE_SIZE - 1));
    assign o_sts.out_free   = !r_out_valid || m_axis_tready;

endmodule

FILE: src/double_hash_open_address_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_open_address_table_top
// Open-addressed hash table with double hashing over TABLE_SIZE slots.
// ----------------------------------------------------------------------------
// Each request (insert, delete or search a key) gives exactly one response
// (status and slot). A request reduces the key to its two residues (one
// 4-bit digit per cycle), sets up the probe walk, checks each probe in two
// steps (address, then compare against the key RAM's registered read data)
// and loads the output register; a walk visits at most all 13 slots. An
// unknown operation skips the probe walk and goes straight to the output.
// One request is in flight at a time; the next one is taken the cycle after
// the response is loaded, even if that response has not yet been taken
// downstream. Slot marks clear at reset; key storage is not initialized and
// is only compared in slots marked full.
// ----------------------------------------------------------------------------
module double_hash_open_address_table_top
    import dhoat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [30:0] key
    input  logic [FUNC_W-1:0]    s_axis_tuser,   // [1:0] func
    // Response stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [3:0] slot
    output logic [STATUS_W-1:0]  m_axis_tuser    // [1:0] status
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Controller
    dhoat_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    // Datapath
    dhoat_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

endmodule

FILE: tb/double_hash_open_address_table_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_open_address_table_top_test
// Self-checking bench for the double-hashed open-address table. A short
// directed sequence covers the empty table, the largest key, duplicates, a
// full table, a miss after a full probe walk and the unknown operation. After
// it comes a long random mix of insert/delete/search on a small pool of keys,
// some of which share their whole probe path. A shadow copy of the table
// predicts each response. Both stream sides idle and stall at random, and
// once the response side holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module double_hash_open_address_table_top_test;
    import dhoat_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1725;
    localparam int QUIET_TAIL     = 250;   // last requests sent with no idling
    localparam int HOLD_AT        = 600;   // random request that starts the long hold
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int POOL_SIZE      = 24;
    localparam int REPORT_LIMIT   = 10;

    // Keys that differ by a multiple of 13*11 share their whole probe path
    localparam int unsigned PATH_PERIOD = TABLE_SIZE * (TABLE_SIZE - 2);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_resp;

    typedef struct packed {
        bit    pinned;
        t_resp want;
    } t_pin;

    typedef struct {
        logic [FUNC_W-1:0]   op;
        logic [KEY_W-1:0]    key;
        bit                  pinned;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // [30:0] key
    logic [FUNC_W-1:0]    s_axis_tuser;   // [1:0] func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // [3:0] slot
    logic [STATUS_W-1:0]  m_axis_tuser;   // [1:0] status

    // Shadow copy of the table
    logic [KEY_W-1:0] shadow_keys  [TABLE_SIZE];
    t_mark            shadow_marks [TABLE_SIZE];

    t_resp expected_responses[$];
    t_pin  typed_answers[$];

    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int  mismatch_count;
    int  op_count[4];
    int  outcome_count[3];
    int  idle_cycles;
    bit  sender_gaps;
    bit  sink_stalls;
    bit  hold_outputs;

    // Directed sequence: typed answers only where obvious from an empty table
    t_row directed_rows [0:24] = '{
        '{FUNC_SEARCH, 31'd0,          1'b1, STAT_MISSING, 4'd0},
        '{FUNC_DELETE, 31'd7,          1'b1, STAT_MISSING, 4'd0},
        '{FUNC_UNUSED, 31'h7FFFFFFF,   1'b1, STAT_MISSING, 4'd0},
        '{FUNC_INSERT, 31'd0,          1'b1, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'h7FFFFFFF,   1'b1, STAT_OK,      4'd10},
        '{FUNC_INSERT, 31'd0,          1'b0, STAT_OK,      4'd0},  // duplicate
        '{FUNC_SEARCH, 31'd0,          1'b0, STAT_OK,      4'd0},
        '{FUNC_DELETE, 31'd0,          1'b0, STAT_OK,      4'd0},
        '{FUNC_SEARCH, 31'd0,          1'b0, STAT_OK,      4'd0},  // finds the copy
        '{FUNC_INSERT, 31'h55555555,   1'b0, STAT_OK,      4'd0},  // fill the table
        '{FUNC_INSERT, 31'h2AAAAAAA,   1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'd13,         1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'd26,         1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'd715,        1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'h40000000,   1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'h7FFFFFFE,   1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'h0000FFFF,   1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'h7FFF0000,   1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'd12,         1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'd11,         1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'h12345678,   1'b0, STAT_OK,      4'd0},  // table full
        '{FUNC_SEARCH, 31'h3C3C3C3C,   1'b0, STAT_OK,      4'd0},  // miss, full walk
        '{FUNC_DELETE, 31'h7FFFFFFF,   1'b0, STAT_OK,      4'd0},
        '{FUNC_INSERT, 31'h2AAAAAAB,   1'b0, STAT_OK,      4'd0},  // reuses deleted slot
        '{FUNC_SEARCH, 31'h7FFFFFFF,   1'b0, STAT_OK,      4'd0}   // deleted never matches
    };

    double_hash_open_address_table_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow table and return its response
    function automatic t_resp hash_table_apply(input logic [FUNC_W-1:0] op,
                                               input logic [KEY_W-1:0]  k);
        int unsigned pos;
        int unsigned stride;
        bit          hit;
        t_resp       r;
        pos    = k % TABLE_SIZE;
        stride = 1 + k % (TABLE_SIZE - 2);
        hit    = 1'b0;
        r      = '{status: STAT_MISSING, slot: '0};
        if (op == FUNC_INSERT) begin
            r.status = STAT_FULL;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                if (!hit && shadow_marks[pos] != MARK_FULL) begin
                    shadow_keys[pos]  = k;
                    shadow_marks[pos] = MARK_FULL;
                    r = '{status: STAT_OK, slot: pos[SLOT_W-1:0]};
                    hit = 1'b1;
                end
                pos = (pos + stride) % TABLE_SIZE;
            end
        end else if (op == FUNC_DELETE || op == FUNC_SEARCH) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                if (!hit && shadow_marks[pos] == MARK_FULL && shadow_keys[pos] == k) begin
                    if (op == FUNC_DELETE) begin
                        shadow_marks[pos] = MARK_DELETED;
                    end
                    r = '{status: STAT_OK, slot: pos[SLOT_W-1:0]};
                    hit = 1'b1;
                end
                pos = (pos + stride) % TABLE_SIZE;
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_resp want, input t_resp got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected status %0d slot %0d, got status %0d slot %0d",
                     $realtime, what, want.status, want.slot, got.status, got.slot);
        end
    endtask

    // Mostly keys from the pool so deletes and searches hit; the rest fresh
    function automatic logic [KEY_W-1:0] pick_key();
        int idx;
        idx = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 99) < 3) begin
            key_pool[idx] = KEY_W'($urandom);
        end
        if ($urandom_range(0, 99) < 80) begin
            return key_pool[idx];
        end
        return KEY_W'($urandom);
    endfunction

    function automatic logic [FUNC_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42) return FUNC_INSERT;
        if (r < 70) return FUNC_DELETE;
        if (r < 95) return FUNC_SEARCH;
        return FUNC_UNUSED;
    endfunction

    // Offer one request and wait for its transaction; valid stays up when back to back
    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                                input bit pinned, input t_resp want);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        typed_answers.push_back('{pinned: pinned, want: want});
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - KEY_W){1'b0}}, k};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Transaction monitor: predict on requests, check responses
    always @(posedge i_clk) begin : observe
        t_resp predicted;
        t_resp got;
        t_resp want;
        t_pin  pin;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted = hash_table_apply(s_axis_tuser, s_axis_tdata[KEY_W-1:0]);
                pin = '0;
                if (typed_answers.size() != 0) begin
                    pin = typed_answers.pop_front();
                end
                want = pin.pinned ? pin.want : predicted;
                expected_responses.push_back(want);
                op_count[s_axis_tuser]++;
                outcome_count[want.status]++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{status: m_axis_tuser, slot: m_axis_tdata[SLOT_W-1:0]};
                if (expected_responses.size() == 0) begin
                    note_mismatch("response with nothing pending", '0, got);
                end else begin
                    want = expected_responses.pop_front();
                    if (got.status != want.status) begin
                        note_mismatch("status field", want, got);
                    end else if (got.slot != want.slot) begin
                        note_mismatch("slot field", want, got);
                    end
                end
            end
        end
    end

    // Watchdog: cycles without any transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Response side: random stalls, one long hold to back up the request side
    initial begin : response_sink
        int n;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_outputs) begin
                hold_outputs = 1'b0;
                m_axis_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        t_resp want;
        bit    calm;
        mismatch_count = 0;
        idle_cycles    = 0;
        hold_outputs   = 1'b0;
        sender_gaps    = 1'b1;
        sink_stalls    = 1'b1;
        op_count       = '{default: 0};
        outcome_count  = '{default: 0};
        for (int i = 0; i < TABLE_SIZE; i++) begin
            shadow_keys[i]  = '0;
            shadow_marks[i] = MARK_EMPTY;
        end
        // Pool: edge keys, random keys, and groups sharing one probe path
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = KEY_W'($urandom);
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int g = 0; g < 3; g++) begin
            key_pool[12 + 4 * g] = KEY_W'($urandom_range(0, 32'h7FFF_0000));
            for (int j = 1; j < 4; j++) begin
                key_pool[12 + 4 * g + j] = KEY_W'(key_pool[12 + 4 * g] + j * PATH_PERIOD);
            end
        end

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_INSERT;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        foreach (directed_rows[r]) begin
            want = '{status: directed_rows[r].status, slot: directed_rows[r].slot};
            send_request(directed_rows[r].op, directed_rows[r].key,
                         directed_rows[r].pinned, want);
        end

        // Random part, with stretches free of idling and a quiet tail
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm        = ((n / 120) % 3 == 2) || (n >= RANDOM_ITEMS - QUIET_TAIL);
            sender_gaps = !calm;
            sink_stalls = !calm;
            if (n == HOLD_AT) begin
                hold_outputs = 1'b1;
            end
            send_request(pick_op(), pick_key(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow for anything stray
        do @(posedge i_clk); while (expected_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_responses.size() != 0) begin
            mismatch_count += expected_responses.size();
            $display("%0d responses never arrived", expected_responses.size());
        end

        $display("Covered %0d requests: %0d insert, %0d delete, %0d search, %0d unknown op",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Outcomes: %0d done/found, %0d not found, %0d table full; %0d mismatches",
                 outcome_count[0], outcome_count[1], outcome_count[2], mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
